### sv/fpa_pkg.sv
// Shared types, op codes and constants for the fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

    localparam int FPA_FRAC_BITS = 8;

    // Quotient bits resolved per divider stage and the resulting stage count.
    localparam int FPA_DIV_STEPS = 2;
    localparam int FPA_DIV_STAGES = 32 / FPA_DIV_STEPS;

    localparam int FPA_OUT_W = 40;

    localparam logic [31:0] FPA_SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] FPA_SAT_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        FPA_ADD     = 4'd0,
        FPA_SUB     = 4'd1,
        FPA_MUL     = 4'd2,
        FPA_DIV     = 4'd3,
        FPA_GT      = 4'd4,
        FPA_LT      = 4'd5,
        FPA_GE      = 4'd6,
        FPA_LE      = 4'd7,
        FPA_EQ      = 4'd8,
        FPA_NE      = 4'd9,
        FPA_MIN     = 4'd10,
        FPA_MAX     = 4'd11,
        FPA_INC     = 4'd12,
        FPA_DEC     = 4'd13,
        FPA_TOINT   = 4'd14,
        FPA_FROMINT = 4'd15
    } fpa_op_t;

    // Per-item state carried down the divider stages to the output stage.
    typedef struct packed {
        logic        is_arith;  // take the result from the magnitude path
        logic        is_div;    // run the divider steps on rem and mag
        logic        neg;
        logic        huge;      // magnitude is 2^32 or more
        logic [31:0] res;       // result of the simple ops
        logic        cmp;
        logic        ovf;
        logic        dz;
        logic [31:0] mag;       // product magnitude, or dividend/quotient shift word
        logic [31:0] rem;
        logic [31:0] divisor;
    } fpa_lane_t;

endpackage

`default_nettype wire

### sv/fixed_point_alu_unit.sv
// Top level of the pipelined signed fixed-point ALU.
//
// Usage: present an op code on s_tuser and the two raw operands on s_tdata; one
// result per accepted item comes out on m_tdata in the order the items went in.
// Input transfers on s_tvalid & s_tready, output transfers on m_tvalid & m_tready.
// An input transfer passes through three front stages (magnitudes and simple
// ops, 32x32 multiply, rounding and divide setup), 16 divider stages resolving
// two quotient bits each, and the output register, before m_tvalid rises.
// One item per cycle unless the receiver stalls; every op takes the same path so order holds.
// When the receiver stalls the whole pipeline holds; a one-entry skid register
// in front still takes one more transfer, after which s_tready drops until the
// pipeline moves again. Nothing is dropped or repeated across a stall.
// Reset empties the pipeline and the skid register; s_tready is high after reset.
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_alu_unit #(
    parameter int FRAC_BITS = fpa_pkg::FPA_FRAC_BITS
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [63:0]                      s_tdata,  // operand_a[31:0], operand_b[63:32]
    input  wire  [3:0]                       s_tuser,  // op[3:0]
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [fpa_pkg::FPA_OUT_W-1:0]    m_tdata   // result_value[31:0], compare_true[32],
                                                       // overflow[33], divide_by_zero[34]
);
    import fpa_pkg::*;

    logic             en;
    logic             accept;
    logic             skid_valid_reg, skid_valid_next;
    fpa_op_t          skid_op_reg;
    logic [31:0]      skid_a_reg, skid_b_reg;

    logic             front_in_valid;
    fpa_op_t          front_op;
    logic signed [31:0] front_a, front_b;

    logic [FPA_DIV_STAGES:0] div_valid;
    fpa_lane_t               div_lane [0:FPA_DIV_STAGES];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // Drain the skid entry first; otherwise feed the transfer straight in.
    assign front_in_valid = skid_valid_reg || accept;
    assign front_op = skid_valid_reg ? skid_op_reg : fpa_op_t'(s_tuser);
    assign front_a  = skid_valid_reg ? skid_a_reg : s_tdata[31:0];
    assign front_b  = skid_valid_reg ? skid_b_reg : s_tdata[63:32];

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (en)
        begin
            skid_valid_next = 1'b0;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && accept)
        begin
            skid_op_reg <= fpa_op_t'(s_tuser);
            skid_a_reg  <= s_tdata[31:0];
            skid_b_reg  <= s_tdata[63:32];
        end
    end

    fpa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_in_valid),
        .in_op     (front_op),
        .in_a      (front_a),
        .in_b      (front_b),
        .out_valid (div_valid[0]),
        .out_lane  (div_lane[0])
    );

    for (genvar g = 0; g < FPA_DIV_STAGES; g++)
    begin : g_div
        fpa_div_stage u_div_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (div_valid[g]),
            .in_lane   (div_lane[g]),
            .out_valid (div_valid[g+1]),
            .out_lane  (div_lane[g+1])
        );
    end

    fpa_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid[FPA_DIV_STAGES]),
        .in_lane   (div_lane[FPA_DIV_STAGES]),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

### sv/fpa_front.sv
// Front stages: operand magnitudes and simple ops, multiply, rounding and divide setup.
`timescale 1ns / 1ps
`default_nettype none

module fpa_front #(
    parameter int FRAC_BITS = fpa_pkg::FPA_FRAC_BITS
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      en,
    input  wire                      in_valid,
    input  wire fpa_pkg::fpa_op_t    in_op,
    input  wire logic signed [31:0]  in_a,
    input  wire logic signed [31:0]  in_b,
    output logic                     out_valid,
    output fpa_pkg::fpa_lane_t       out_lane
);
    import fpa_pkg::*;

    localparam int NW = 32 + FRAC_BITS;

    // stage 1
    logic        s1_valid_reg;
    logic        s1_is_mul_reg, s1_is_mul_next;
    logic        s1_is_div_reg, s1_is_div_next;
    logic        s1_neg_reg, s1_neg_next;
    logic [31:0] s1_ma_reg, s1_ma_next;
    logic [31:0] s1_mb_reg, s1_mb_next;
    logic [31:0] s1_res_reg, s1_res_next;
    logic        s1_cmp_reg, s1_cmp_next;
    logic        s1_ovf_reg, s1_ovf_next;
    logic        s1_dz_reg, s1_dz_next;

    logic [32:0]        ext_a, ext_b, sum;
    logic               use_sum;
    logic signed [63:0] wide_a, shifted_a;

    // stage 2
    logic          s2_valid_reg;
    logic          s2_is_mul_reg, s2_is_div_reg, s2_neg_reg;
    logic [31:0]   s2_mb_reg;
    logic [31:0]   s2_res_reg;
    logic          s2_cmp_reg, s2_ovf_reg, s2_dz_reg;
    logic [63:0]   s2_prod_reg, s2_prod_next;
    logic [NW-1:0] s2_n_reg, s2_n_next;

    // stage 3
    logic          s3_valid_reg;
    fpa_lane_t     s3_lane_reg, s3_lane_next;
    logic [63:0]   rounded;
    logic [31:0]   n_hi;
    logic          div_huge;

    assign ext_a     = {in_a[31], in_a};
    assign ext_b     = {in_b[31], in_b};
    assign wide_a    = {{32{in_a[31]}}, in_a};
    assign shifted_a = wide_a <<< FRAC_BITS;

    always_comb
    begin
        s1_is_mul_next = 1'b0;
        s1_is_div_next = 1'b0;
        s1_neg_next    = in_a[31] ^ in_b[31];
        s1_ma_next     = in_a[31] ? (~in_a + 32'd1) : in_a;
        s1_mb_next     = in_b[31] ? (~in_b + 32'd1) : in_b;
        s1_res_next    = 32'd0;
        s1_cmp_next    = 1'b0;
        s1_ovf_next    = 1'b0;
        s1_dz_next     = 1'b0;
        use_sum        = 1'b0;
        sum            = 33'd0;
        case (in_op)
            FPA_ADD:
            begin
                sum     = ext_a + ext_b;
                use_sum = 1'b1;
            end
            FPA_SUB:
            begin
                sum     = ext_a - ext_b;
                use_sum = 1'b1;
            end
            FPA_INC:
            begin
                sum     = ext_a + 33'd1;
                use_sum = 1'b1;
            end
            FPA_DEC:
            begin
                sum     = ext_a - 33'd1;
                use_sum = 1'b1;
            end
            FPA_MUL: s1_is_mul_next = 1'b1;
            FPA_DIV:
            begin
                if (in_b == 32'sd0)
                begin
                    s1_dz_next  = 1'b1;
                    s1_res_next = in_a[31] ? FPA_SAT_MIN : FPA_SAT_MAX;
                end
                else
                begin
                    s1_is_div_next = 1'b1;
                end
            end
            FPA_GT:  s1_cmp_next = (in_a > in_b);
            FPA_LT:  s1_cmp_next = (in_a < in_b);
            FPA_GE:  s1_cmp_next = (in_a >= in_b);
            FPA_LE:  s1_cmp_next = (in_a <= in_b);
            FPA_EQ:  s1_cmp_next = (in_a == in_b);
            FPA_NE:  s1_cmp_next = (in_a != in_b);
            FPA_MIN: s1_res_next = (in_a < in_b) ? in_a : in_b;
            FPA_MAX: s1_res_next = (in_a > in_b) ? in_a : in_b;
            FPA_TOINT: s1_res_next = in_a >>> FRAC_BITS;
            FPA_FROMINT:
            begin
                if (shifted_a > 64'sh0000_0000_7FFF_FFFF)
                begin
                    s1_ovf_next = 1'b1;
                    s1_res_next = FPA_SAT_MAX;
                end
                else if (shifted_a < -64'sh0000_0000_8000_0000)
                begin
                    s1_ovf_next = 1'b1;
                    s1_res_next = FPA_SAT_MIN;
                end
                else
                begin
                    s1_res_next = shifted_a[31:0];
                end
            end
            default: ;
        endcase
        if (use_sum)
        begin
            if (sum[32] != sum[31])
            begin
                s1_ovf_next = 1'b1;
                s1_res_next = sum[32] ? FPA_SAT_MIN : FPA_SAT_MAX;
            end
            else
            begin
                s1_res_next = sum[31:0];
            end
        end
    end

    // Multiply magnitudes; form the rounded, scaled dividend for the divider.
    assign s2_prod_next = 64'(s1_ma_reg) * 64'(s1_mb_reg);
    assign s2_n_next    = (NW'(s1_ma_reg) << FRAC_BITS) + NW'(s1_mb_reg >> 1);

    assign rounded  = (s2_prod_reg + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign n_hi     = 32'(s2_n_reg[NW-1:32]);
    // quotient reaches 2^32 when the upper dividend word is not below the divisor
    assign div_huge = (n_hi >= s2_mb_reg);

    always_comb
    begin
        s3_lane_next.is_arith = s2_is_mul_reg | s2_is_div_reg;
        s3_lane_next.is_div   = s2_is_div_reg & ~div_huge;
        s3_lane_next.neg      = s2_neg_reg;
        s3_lane_next.huge     = s2_is_mul_reg ? (|rounded[63:32]) : div_huge;
        s3_lane_next.res      = s2_res_reg;
        s3_lane_next.cmp      = s2_cmp_reg;
        s3_lane_next.ovf      = s2_ovf_reg;
        s3_lane_next.dz       = s2_dz_reg;
        s3_lane_next.mag      = s2_is_mul_reg ? rounded[31:0] : s2_n_reg[31:0];
        s3_lane_next.rem      = n_hi;
        s3_lane_next.divisor  = s2_mb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_is_mul_reg <= s1_is_mul_next;
            s1_is_div_reg <= s1_is_div_next;
            s1_neg_reg    <= s1_neg_next;
            s1_ma_reg     <= s1_ma_next;
            s1_mb_reg     <= s1_mb_next;
            s1_res_reg    <= s1_res_next;
            s1_cmp_reg    <= s1_cmp_next;
            s1_ovf_reg    <= s1_ovf_next;
            s1_dz_reg     <= s1_dz_next;

            s2_is_mul_reg <= s1_is_mul_reg;
            s2_is_div_reg <= s1_is_div_reg;
            s2_neg_reg    <= s1_neg_reg;
            s2_mb_reg     <= s1_mb_reg;
            s2_res_reg    <= s1_res_reg;
            s2_cmp_reg    <= s1_cmp_reg;
            s2_ovf_reg    <= s1_ovf_reg;
            s2_dz_reg     <= s1_dz_reg;
            s2_prod_reg   <= s2_prod_next;
            s2_n_reg      <= s2_n_next;

            s3_lane_reg   <= s3_lane_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_lane  = s3_lane_reg;

endmodule

`default_nettype wire

### sv/fpa_div_stage.sv
// One divider stage: two restoring quotient steps on the carried remainder.
`timescale 1ns / 1ps
`default_nettype none

module fpa_div_stage (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      en,
    input  wire                      in_valid,
    input  wire fpa_pkg::fpa_lane_t  in_lane,
    output logic                     out_valid,
    output fpa_pkg::fpa_lane_t       out_lane
);
    import fpa_pkg::*;

    logic      valid_reg;
    fpa_lane_t lane_reg, lane_next;
    logic [32:0] trial;
    logic [33:0] diff;
    logic        qbit;

    always_comb
    begin
        lane_next = in_lane;
        trial     = 33'd0;
        diff      = 34'd0;
        qbit      = 1'b0;
        if (in_lane.is_div)
        begin
            for (int i = 0; i < FPA_DIV_STEPS; i++)
            begin
                // shift the next dividend bit into the remainder, subtract if it fits
                trial = {lane_next.rem, lane_next.mag[31]};
                diff  = {1'b0, trial} - {2'b00, lane_next.divisor};
                qbit  = ~diff[33];
                lane_next.rem = qbit ? diff[31:0] : trial[31:0];
                lane_next.mag = {lane_next.mag[30:0], qbit};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

`default_nettype wire

### sv/fpa_post.sv
// Output stage: sign and saturate the multiply/divide magnitude, register the result.
`timescale 1ns / 1ps
`default_nettype none

module fpa_post (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              en,
    input  wire                              in_valid,
    input  wire fpa_pkg::fpa_lane_t          in_lane,
    output logic                             out_valid,
    output logic [fpa_pkg::FPA_OUT_W-1:0]    out_data
);
    import fpa_pkg::*;

    logic        valid_reg;
    logic [31:0] res_reg, res_next;
    logic        cmp_reg, ovf_reg, ovf_next, dz_reg;

    always_comb
    begin
        res_next = in_lane.res;
        ovf_next = in_lane.ovf;
        if (in_lane.is_arith)
        begin
            if (in_lane.huge)
            begin
                ovf_next = 1'b1;
                res_next = in_lane.neg ? FPA_SAT_MIN : FPA_SAT_MAX;
            end
            else if (!in_lane.neg && in_lane.mag[31])
            begin
                ovf_next = 1'b1;
                res_next = FPA_SAT_MAX;
            end
            else if (in_lane.neg && in_lane.mag[31] && (|in_lane.mag[30:0]))
            begin
                ovf_next = 1'b1;
                res_next = FPA_SAT_MIN;
            end
            else
            begin
                res_next = in_lane.neg ? (~in_lane.mag + 32'd1) : in_lane.mag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            cmp_reg <= in_lane.cmp;
            ovf_reg <= ovf_next;
            dz_reg  <= in_lane.dz;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {5'b00000, dz_reg, ovf_reg, cmp_reg, res_reg};

endmodule

`default_nettype wire
